// ===== hdl/tsw_pkg.sv =====
`timescale 1ns / 1ps
package tsw_pkg;

  localparam int ECHO_W    = 16;
  localparam int CFG_W     = 11;
  localparam int DIST_W    = 12;
  localparam int CMP_W     = DIST_W + 1;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STAGE_WIDTH      = 3'd0,
    REG_HALF_STAGE_WIDTH = 3'd1,
    REG_RAPID_CHANGE     = 3'd2,
    REG_CLOSE_TO_WALL    = 3'd3,
    REG_FAR_SIDE         = 3'd4,
    REG_FAR_BACK         = 3'd5,
    REG_TOO_CLOSE        = 3'd6,
    REG_BACK_OFF_DIST    = 3'd7
  } tsw_reg_t;

  localparam logic [1:0] ACT_NONE       = 2'd0;
  localparam logic [1:0] ACT_STRAIGHT   = 2'd1;
  localparam logic [1:0] ACT_RIGHT_BACK = 2'd2;
  localparam logic [1:0] ACT_LEFT_BACK  = 2'd3;

  localparam logic [1:0] LOC_CLOSE = 2'd0;
  localparam logic [1:0] LOC_MID   = 2'd1;
  localparam logic [1:0] LOC_FAR   = 2'd2;

  localparam logic signed [CMP_W-1:0] LOC_CLOSE_CM = 13'sd30;
  localparam logic signed [CMP_W-1:0] LOC_MID_CM   = 13'sd80;

  typedef struct packed {
    logic [ECHO_W-1:0] left_echo_us;
    logic [ECHO_W-1:0] back_echo_us;
    logic [ECHO_W-1:0] right_echo_us;
  } tsw_in_t;

  typedef struct packed {
    logic       left_near;
    logic       left_distant;
    logic       left_too_near;
    logic       back_near;
    logic       back_distant;
    logic       back_too_near;
    logic       right_near;
    logic       right_distant;
    logic       right_too_near;
    logic       right_is_farther;
    logic [1:0] back_action;
    logic [1:0] location;
  } tsw_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] stage_width;
    logic [CFG_W-1:0] half_stage_width;
    logic [CFG_W-1:0] rapid_change;
    logic [CFG_W-1:0] close_to_wall;
    logic [CFG_W-1:0] far_side;
    logic [CFG_W-1:0] far_back;
    logic [CFG_W-1:0] too_close;
    logic [CFG_W-1:0] back_off_distance;
  } tsw_cfg_t;

endpackage

// ===== hdl/tsw_lane.sv =====
`timescale 1ns / 1ps
module tsw_lane
  import tsw_pkg::*;
#(
  parameter int US_PER_CM = 58
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ECHO_W-1:0]        echo,
  output logic signed [DIST_W-1:0] dist_cm
);

  localparam int DIV    = (US_PER_CM < 1) ? 1 : US_PER_CM;
  localparam int SHIFT  = ECHO_W + $clog2(DIV);
  localparam int PROD_W = ECHO_W + SHIFT + 1;
  localparam longint unsigned MAGIC = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [SHIFT:0] MAGIC_V = MAGIC[SHIFT:0];

  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              nil_r, nil_nxt;

  assign prod_nxt = PROD_W'(echo) * PROD_W'(MAGIC_V);
  assign nil_nxt  = (echo == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      nil_r  <= nil_nxt;
    end
  end

  assign dist_cm = nil_r ? '1 : signed'({1'b0, prod_r[SHIFT +: DIST_W-1]});

endmodule

// ===== hdl/tsw_merge.sv =====
`timescale 1ns / 1ps
module tsw_merge
  import tsw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  tsw_cfg_t                 cfg,
  input  logic signed [DIST_W-1:0] left_dist,
  input  logic signed [DIST_W-1:0] back_dist,
  input  logic signed [DIST_W-1:0] right_dist,
  output tsw_out_t                 out_word
);

  function automatic logic jump_flag(input logic signed [CMP_W-1:0] now_d,
                                     input logic signed [CMP_W-1:0] old_d,
                                     input logic signed [CMP_W-1:0] thr,
                                     input logic                    flag);
    logic signed [CMP_W-1:0] d;
    logic signed [CMP_W-1:0] a;
    d = now_d - old_d;
    a = (d < 0) ? -d : d;
    return (a >= thr) ? (d > 0) : flag;
  endfunction

  function automatic logic signed [CMP_W-1:0] ext_cfg(input logic [CFG_W-1:0] v);
    return signed'({{(CMP_W-CFG_W){1'b0}}, v});
  endfunction

  logic signed [DIST_W-1:0] left_r, back_r, right_r;
  logic                     left_ok_r, back_ok_r, right_ok_r;
  logic                     left_ok_nxt, back_ok_nxt, right_ok_nxt;
  tsw_out_t                 out_r, out_nxt;

  logic signed [CMP_W-1:0] nl, nb, nr, ol, ob, orr;
  logic signed [CMP_W-1:0] sw, hsw, rc, ctw, fs, fb, tc, bod;
  logic                    ln, rn;

  assign nl  = CMP_W'(left_dist);
  assign nb  = CMP_W'(back_dist);
  assign nr  = CMP_W'(right_dist);
  assign ol  = CMP_W'(left_r);
  assign ob  = CMP_W'(back_r);
  assign orr = CMP_W'(right_r);
  assign sw  = ext_cfg(cfg.stage_width);
  assign hsw = ext_cfg(cfg.half_stage_width);
  assign rc  = ext_cfg(cfg.rapid_change);
  assign ctw = ext_cfg(cfg.close_to_wall);
  assign fs  = ext_cfg(cfg.far_side);
  assign fb  = ext_cfg(cfg.far_back);
  assign tc  = ext_cfg(cfg.too_close);
  assign bod = ext_cfg(cfg.back_off_distance);

  always_comb begin
    if ((nl + nr) >= sw) begin
      left_ok_nxt  = 1'b1;
      right_ok_nxt = 1'b1;
    end else begin
      left_ok_nxt  = jump_flag(nl, ol, rc, left_ok_r);
      right_ok_nxt = jump_flag(nr, orr, rc, right_ok_r);
    end
    back_ok_nxt = jump_flag(nb, ob, rc, back_ok_r);
  end

  always_comb begin
    out_nxt = '0;
    if (left_ok_nxt) begin
      ln                   = (nl <= ctw);
      out_nxt.left_distant = (nl >= fs);
    end else if (right_ok_nxt) begin
      ln                   = (nr >= fs);
      out_nxt.left_distant = (nr <= ctw);
    end else begin
      ln                   = 1'b0;
      out_nxt.left_distant = 1'b0;
    end
    if (right_ok_nxt) begin
      rn                    = (nr <= ctw);
      out_nxt.right_distant = (nr >= fs);
    end else if (left_ok_nxt) begin
      rn                    = (nl >= fs);
      out_nxt.right_distant = (nl <= ctw);
    end else begin
      rn                    = 1'b0;
      out_nxt.right_distant = 1'b0;
    end
    out_nxt.left_near      = ln;
    out_nxt.right_near     = rn;
    out_nxt.left_too_near  = (nl <= tc);
    out_nxt.back_too_near  = (nb <= tc);
    out_nxt.right_too_near = (nr <= tc);
    out_nxt.back_near      = back_ok_nxt && (nb <= ctw);
    out_nxt.back_distant   = back_ok_nxt && (nb >= fb);
    if (right_ok_nxt) begin
      out_nxt.right_is_farther = left_ok_nxt ? (nr >= nl) : (nr >= hsw);
    end else begin
      out_nxt.right_is_farther = left_ok_nxt && (nl <= hsw);
    end
    if (nb >= bod) begin
      if (ln) begin
        out_nxt.back_action = ACT_RIGHT_BACK;
      end else if (rn) begin
        out_nxt.back_action = ACT_LEFT_BACK;
      end else begin
        out_nxt.back_action = ACT_STRAIGHT;
      end
    end else begin
      out_nxt.back_action = ACT_NONE;
    end
    if (nb <= LOC_CLOSE_CM) begin
      out_nxt.location = LOC_CLOSE;
    end else if (nb <= LOC_MID_CM) begin
      out_nxt.location = LOC_MID;
    end else begin
      out_nxt.location = LOC_FAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r     <= '0;
      back_r     <= '0;
      right_r    <= '0;
      left_ok_r  <= 1'b0;
      back_ok_r  <= 1'b0;
      right_ok_r <= 1'b0;
    end else if (en) begin
      left_r     <= left_dist;
      back_r     <= back_dist;
      right_r    <= right_dist;
      left_ok_r  <= left_ok_nxt;
      back_ok_r  <= back_ok_nxt;
      right_ok_r <= right_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_word = out_r;

endmodule

// ===== hdl/three_sonar_wall_classifier.sv =====
`timescale 1ns / 1ps
// Three-sonar wall classifier.
// Input channel (in_valid / in_stall / in_data): one word per ping, holding
// the left, back and right echo times in microseconds, zero meaning no echo.
// Output channel (out_valid / out_stall / out_data): one word of wall flags,
// back-off action and coarse location for every input word, in order.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; write the eight thresholds only while no word is in flight.
// The lane stage registers the three echo-to-centimetre products (one
// reciprocal multiplier per sensor lane); the merge stage then updates the
// per-sensor valid flags and registers the result word. Throughput is one
// word per cycle while the receiver does not stall.
// Reset clears the stored distances and flags, loads the default
// thresholds and empties the pipeline. When the receiver stalls, the result
// word holds; one more word may enter the lane stage, then in_stall rises.
module three_sonar_wall_classifier
  import tsw_pkg::*;
#(
  parameter int US_PER_CM = 58
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tsw_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tsw_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  tsw_cfg_t cfg_r, cfg_nxt;
  logic     s1_valid_r, s1_valid_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     adv1, adv2;

  logic signed [DIST_W-1:0] left_dist, back_dist, right_dist;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (tsw_reg_t'(cfg_index))
        REG_STAGE_WIDTH:      cfg_nxt.stage_width       = cfg_data;
        REG_HALF_STAGE_WIDTH: cfg_nxt.half_stage_width  = cfg_data;
        REG_RAPID_CHANGE:     cfg_nxt.rapid_change      = cfg_data;
        REG_CLOSE_TO_WALL:    cfg_nxt.close_to_wall     = cfg_data;
        REG_FAR_SIDE:         cfg_nxt.far_side          = cfg_data;
        REG_FAR_BACK:         cfg_nxt.far_back          = cfg_data;
        REG_TOO_CLOSE:        cfg_nxt.too_close         = cfg_data;
        REG_BACK_OFF_DIST:    cfg_nxt.back_off_distance = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stage_width       <= 11'd182;
      cfg_r.half_stage_width  <= 11'd91;
      cfg_r.rapid_change      <= 11'd20;
      cfg_r.close_to_wall     <= 11'd30;
      cfg_r.far_side          <= 11'd60;
      cfg_r.far_back          <= 11'd60;
      cfg_r.too_close         <= 11'd10;
      cfg_r.back_off_distance <= 11'd100;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign adv2          = !out_valid_r || !out_stall;
  assign adv1          = !s1_valid_r || adv2;
  assign in_stall      = !adv1;
  assign s1_valid_nxt  = adv1 ? in_valid : s1_valid_r;
  assign out_valid_nxt = adv2 ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  tsw_lane #(.US_PER_CM(US_PER_CM)) u_lane_left (
    .clk     (clk),
    .en      (adv1 && in_valid),
    .echo    (in_data.left_echo_us),
    .dist_cm (left_dist)
  );

  tsw_lane #(.US_PER_CM(US_PER_CM)) u_lane_back (
    .clk     (clk),
    .en      (adv1 && in_valid),
    .echo    (in_data.back_echo_us),
    .dist_cm (back_dist)
  );

  tsw_lane #(.US_PER_CM(US_PER_CM)) u_lane_right (
    .clk     (clk),
    .en      (adv1 && in_valid),
    .echo    (in_data.right_echo_us),
    .dist_cm (right_dist)
  );

  tsw_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (s1_valid_r && adv2),
    .cfg        (cfg_r),
    .left_dist  (left_dist),
    .back_dist  (back_dist),
    .right_dist (right_dist),
    .out_word   (out_data)
  );

  assign out_valid = out_valid_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  a_lane_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_stall) |=> out_valid)
    else $error("lane word not forwarded to output");

  a_lane_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> s1_valid_r)
    else $error("lane word lost during output stall");

endmodule

// ===== verif/three_sonar_wall_classifier_tb.sv =====
`timescale 1ns / 1ps
module three_sonar_wall_classifier_tb;
  import tsw_pkg::*;

  localparam int US_PER_CM = 58;
  localparam int N_REGS = 8;
  localparam logic [CFG_W-1:0] THR_DEFAULT [N_REGS] = '{
    11'd182, 11'd91, 11'd20, 11'd30, 11'd60, 11'd60, 11'd10, 11'd100
  };
  localparam tsw_out_t ALL_MISS = {10'b0010010010, ACT_NONE, LOC_CLOSE};
  localparam tsw_out_t FAR_OPEN = {10'b0100100101, ACT_STRAIGHT, LOC_FAR};

  localparam int KIND_RANDOM   = 0;
  localparam int KIND_FULL     = 1;
  localparam int KIND_ZERO     = 2;
  localparam int KIND_MID_HIGH = 3;
  localparam int KIND_ONES     = 4;
  localparam int KIND_DEFAULT  = 5;

  typedef struct {
    tsw_in_t  word;
    bit       typed;
    tsw_out_t want;
  } ping_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  tsw_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  tsw_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  three_sonar_wall_classifier #(.US_PER_CM(US_PER_CM)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  logic [CFG_W-1:0] thr [N_REGS];
  int left_cm = 0;
  int back_cm = 0;
  int right_cm = 0;
  bit left_ok = 1'b0;
  bit back_ok = 1'b0;
  bit right_ok = 1'b0;

  tsw_out_t due_reports [$];
  int mismatches = 0;
  int words_checked = 0;
  int backoff_words = 0;
  int threshold_sets = 0;
  bit steady_send = 1'b0;
  bit steady_drain = 1'b0;

  function automatic int echo_to_cm(logic [ECHO_W-1:0] t);
    if (t == '0) return -1;
    return int'(t) / US_PER_CM;
  endfunction

  function automatic bit jumped(int now, int old, bit flag);
    int d;
    int a;
    d = now - old;
    a = (d < 0) ? -d : d;
    if (a >= int'(thr[REG_RAPID_CHANGE])) return d > 0;
    return flag;
  endfunction

  function automatic bit side_near(bit own_ok, int own, bit oth_ok, int oth);
    if (own_ok) return own <= int'(thr[REG_CLOSE_TO_WALL]);
    if (oth_ok) return int'(thr[REG_FAR_SIDE]) <= oth;
    return 1'b0;
  endfunction

  function automatic bit side_distant(bit own_ok, int own, bit oth_ok, int oth);
    if (own_ok) return int'(thr[REG_FAR_SIDE]) <= own;
    if (oth_ok) return oth <= int'(thr[REG_CLOSE_TO_WALL]);
    return 1'b0;
  endfunction

  function automatic tsw_out_t classify_ping(tsw_in_t w);
    int nl;
    int nb;
    int nr;
    int half;
    tsw_out_t r;
    nl = echo_to_cm(w.left_echo_us);
    nb = echo_to_cm(w.back_echo_us);
    nr = echo_to_cm(w.right_echo_us);
    if (nl + nr >= int'(thr[REG_STAGE_WIDTH])) begin
      left_ok = 1'b1;
      right_ok = 1'b1;
    end else begin
      right_ok = jumped(nr, right_cm, right_ok);
      left_ok = jumped(nl, left_cm, left_ok);
    end
    back_ok = jumped(nb, back_cm, back_ok);
    left_cm = nl;
    back_cm = nb;
    right_cm = nr;
    half = int'(thr[REG_HALF_STAGE_WIDTH]);

    r.left_near = side_near(left_ok, left_cm, right_ok, right_cm);
    r.left_distant = side_distant(left_ok, left_cm, right_ok, right_cm);
    r.left_too_near = left_cm <= int'(thr[REG_TOO_CLOSE]);
    r.back_near = back_ok && back_cm <= int'(thr[REG_CLOSE_TO_WALL]);
    r.back_distant = back_ok && back_cm >= int'(thr[REG_FAR_BACK]);
    r.back_too_near = back_cm <= int'(thr[REG_TOO_CLOSE]);
    r.right_near = side_near(right_ok, right_cm, left_ok, left_cm);
    r.right_distant = side_distant(right_ok, right_cm, left_ok, left_cm);
    r.right_too_near = right_cm <= int'(thr[REG_TOO_CLOSE]);
    if (right_ok) begin
      r.right_is_farther = left_ok ? (right_cm >= left_cm) : (right_cm >= half);
    end else begin
      r.right_is_farther = left_ok && left_cm <= half;
    end
    if (back_cm >= int'(thr[REG_BACK_OFF_DIST])) begin
      if (r.left_near) r.back_action = ACT_RIGHT_BACK;
      else if (r.right_near) r.back_action = ACT_LEFT_BACK;
      else r.back_action = ACT_STRAIGHT;
    end else begin
      r.back_action = ACT_NONE;
    end
    if (back_cm <= int'(LOC_CLOSE_CM)) r.location = LOC_CLOSE;
    else if (back_cm <= int'(LOC_MID_CM)) r.location = LOC_MID;
    else r.location = LOC_FAR;
    return r;
  endfunction

  function automatic logic [ECHO_W-1:0] echo_draw();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) return '0;
    if (pick == 2) return ECHO_W'($urandom_range(0, 65535));
    if (pick == 3) return ($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF;
    return ECHO_W'($urandom_range(0, 250) * US_PER_CM + $urandom_range(0, US_PER_CM - 1));
  endfunction

  function automatic int gap_draw(bit steady);
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic ping_row_t ping_row(int l, int b, int r, bit typed = 1'b0,
                                         tsw_out_t want = '0);
    ping_row_t row;
    row.word.left_echo_us = ECHO_W'(l);
    row.word.back_echo_us = ECHO_W'(b);
    row.word.right_echo_us = ECHO_W'(r);
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  task automatic offer_ping(input tsw_in_t w, input bit typed, input tsw_out_t want);
    int gap;
    tsw_out_t pred;
    gap = gap_draw(steady_send);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = classify_ping(w);
    due_reports.push_back(typed ? want : pred);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  task automatic apply_thresholds(input logic [CFG_W-1:0] vals [N_REGS]);
    for (int r = 0; r < N_REGS; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data <= vals[r];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      thr[r] = vals[r];
    end
    cfg_valid <= 1'b0;
    threshold_sets++;
  endtask

  initial begin : drain
    int hold;
    bit bad;
    tsw_out_t got;
    tsw_out_t want;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      // back up the pipe once so the input side has to stall
      hold = (words_checked == 120) ? 60 : gap_draw(steady_drain);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = out_data;
      words_checked++;
      if (got.back_action != ACT_NONE) backoff_words++;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %p", got);
      end else begin
        want = due_reports.pop_front();
        bad = (got.left_near !== want.left_near) ||
              (got.left_distant !== want.left_distant) ||
              (got.left_too_near !== want.left_too_near) ||
              (got.back_near !== want.back_near) ||
              (got.back_distant !== want.back_distant) ||
              (got.back_too_near !== want.back_too_near) ||
              (got.right_near !== want.right_near) ||
              (got.right_distant !== want.right_distant) ||
              (got.right_too_near !== want.right_too_near) ||
              (got.right_is_farther !== want.right_is_farther) ||
              (got.back_action !== want.back_action) ||
              (got.location !== want.location);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("word %0d mismatch\n  expected %p\n  actual   %p",
                     words_checked, want, got);
          end
        end
      end
    end
  end

  initial begin : stimulus
    ping_row_t rows [$];
    tsw_in_t last_word;
    logic [CFG_W-1:0] vals [N_REGS];
    int kinds [7];

    thr = THR_DEFAULT;
    kinds = '{KIND_RANDOM, KIND_RANDOM, KIND_ZERO, KIND_MID_HIGH, KIND_ONES,
              KIND_FULL, KIND_DEFAULT};

    rows.push_back(ping_row(0, 0, 0, 1'b1, ALL_MISS));
    rows.push_back(ping_row(65535, 65535, 65535, 1'b1, FAR_OPEN));
    rows.push_back(ping_row(0, 0, 0, 1'b1, ALL_MISS));
    rows.push_back(ping_row(1, 1, 1));
    rows.push_back(ping_row(57, 58, 59));
    rows.push_back(ping_row(1160, 6960, 0));
    rows.push_back(ping_row(0, 6960, 1160));
    rows.push_back(ping_row(2320, 2900, 0));
    rows.push_back(ping_row(2320, 2900, 1450));
    rows.push_back(ping_row(5800, 4640, 5800));
    rows.push_back(ping_row(5510, 4698, 5220));
    rows.push_back(ping_row(3480, 1740, 3480));
    rows.push_back(ping_row(4060, 5800, 1160));
    rows.push_back(ping_row(290, 580, 638));
    rows.push_back(ping_row(65535, 0, 1));
    rows.push_back(ping_row(0, 65535, 0));
    rows.push_back(ping_row(1, 32768, 21845));
    rows.push_back(ping_row(5278, 3000, 0));
    rows.push_back(ping_row(0, 0, 5278));
    rows.push_back(ping_row(0, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    steady_send = ($urandom_range(0, 1) == 0);
    steady_drain = ($urandom_range(0, 1) == 0);
    foreach (rows[i]) offer_ping(rows[i].word, rows[i].typed, rows[i].want);
    settle();

    foreach (kinds[p]) begin
      for (int r = 0; r < N_REGS; r++) begin
        case (kinds[p])
          KIND_RANDOM:   vals[r] = CFG_W'($urandom_range(0, 300));
          KIND_FULL:     vals[r] = CFG_W'($urandom_range(0, 2047));
          KIND_ZERO:     vals[r] = '0;
          KIND_MID_HIGH: vals[r] = 11'd1200;
          KIND_ONES:     vals[r] = '1;
          default:       vals[r] = THR_DEFAULT[r];
        endcase
      end
      apply_thresholds(vals);
      steady_send = ($urandom_range(0, 2) == 0);
      steady_drain = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < 90; i++) begin
        // repeat the last ping now and then to exercise the zero-jump case
        if (i == 0 || $urandom_range(0, 7) != 0) begin
          last_word.left_echo_us = echo_draw();
          last_word.back_echo_us = echo_draw();
          last_word.right_echo_us = echo_draw();
        end
        offer_ping(last_word, 1'b0, '0);
      end
      settle();
    end

    for (int k = 0; k < 5000 && due_reports.size() != 0; k++) @(posedge clk);
    repeat (6) @(posedge clk);
    if (due_reports.size() != 0) begin
      mismatches++;
      $display("%0d result words never arrived", due_reports.size());
    end
    $display("Checked %0d result words under %0d threshold sets (defaults, random,",
             words_checked, threshold_sets);
    $display("all-zero, 1200 and full-scale); %0d words advised backing up.",
             backoff_words);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
